### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; they compile away under
// synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define LGR_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define LGR_ASSERT_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define LGR_ASSERT(name, clk, rst, prop, msg)
`define LGR_ASSERT_NEVER(name, clk, rst, cond, msg)

`endif

`endif

### src/lgr_pkg.sv
// ---------------------------------------------------------------------------
// Life generation row stream package
// Widths, limits, register indexes and the result type shared by the block.
// ---------------------------------------------------------------------------
`default_nettype none

package lgr_pkg;

  // Widest row the lanes can hold and the frame height limit.
  localparam int ROW_BITS = 64;
  localparam int MAX_ROWS = 1024;

  // Fixed field widths.
  localparam int CELL_W   = 64;
  localparam int ROWNUM_W = 10;
  localparam int WIDTH_W  = 7;
  localparam int HEIGHT_W = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;

  // Output bus packing: cells, then row number, padded to whole bytes.
  localparam int OUT_BITS = CELL_W + ROWNUM_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Result queue depth and its count width.
  localparam int QUEUE_DEPTH = 3;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } lgr_reg_t;

  // One result row.
  typedef struct packed {
    logic [CELL_W-1:0]   cells;
    logic [ROWNUM_W-1:0] row;
    logic                done;
  } lgr_result_t;

  // Results produced by one accepted input row.
  typedef struct packed {
    logic [1:0]  count;
    lgr_result_t first;
    lgr_result_t second;
  } lgr_push_t;

endpackage

`default_nettype wire

### src/lgr_lane.sv
// ---------------------------------------------------------------------------
// Life generation lane
// Next state of one cell from its 3x3 neighborhood under the B3/S23 rule.
// ---------------------------------------------------------------------------
`default_nettype none

module lgr_lane import lgr_pkg::*; (
  input  wire logic [2:0] above,
  input  wire logic [2:0] mid,
  input  wire logic [2:0] below,
  output logic            next_cell
);

  logic [3:0] neighbors;

  // Count the eight neighbors; the center of the middle row is excluded.
  assign neighbors = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
                   + 4'(mid[0])   + 4'(mid[2])
                   + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);

  // Birth on three, survival on two or three.
  assign next_cell = (neighbors == 4'd3) || (mid[1] && (neighbors == 4'd2));

endmodule

`default_nettype wire

### src/lgr_row_unit.sv
// ---------------------------------------------------------------------------
// Life generation row unit
// One lane per cell side by side; the lane outputs merge into a masked row.
// ---------------------------------------------------------------------------
`default_nettype none

module lgr_row_unit import lgr_pkg::*; (
  input  wire logic [CELL_W-1:0] above,
  input  wire logic [CELL_W-1:0] mid,
  input  wire logic [CELL_W-1:0] below,
  input  wire logic [CELL_W-1:0] mask,
  output logic      [CELL_W-1:0] next_row
);

  logic [CELL_W+1:0] above_pad;
  logic [CELL_W+1:0] mid_pad;
  logic [CELL_W+1:0] below_pad;
  logic [CELL_W-1:0] lane_out;

  // Dead cells beyond both edges of the grid.
  assign above_pad = {1'b0, above, 1'b0};
  assign mid_pad   = {1'b0, mid, 1'b0};
  assign below_pad = {1'b0, below, 1'b0};

  // One lane for each cell position.
  for (genvar j = 0; j < CELL_W; j++) begin : g_lane
    lgr_lane u_lane (
      .above     (above_pad[j+2:j]),
      .mid       (mid_pad[j+2:j]),
      .below     (below_pad[j+2:j]),
      .next_cell (lane_out[j])
    );
  end

  // Merge the lanes; cells past the grid width read as dead.
  assign next_row = lane_out & mask;

endmodule

`default_nettype wire

### src/lgr_out_queue.sv
// ---------------------------------------------------------------------------
// Life generation result queue
// Short shift queue that takes up to two results per cycle and hands one out.
// ---------------------------------------------------------------------------
`default_nettype none

module lgr_out_queue import lgr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_en,
  input  wire lgr_push_t         push,
  input  wire logic              pop,
  output lgr_result_t            head,
  output logic                   head_valid,
  output logic                   room
);

  lgr_result_t             entries [QUEUE_DEPTH];
  lgr_result_t             entries_next [QUEUE_DEPTH];
  logic [QCNT_W-1:0]       count;
  logic [QCNT_W-1:0]       count_next;
  logic [QCNT_W-1:0]       count_popped;
  logic [1:0]              push_count;

  assign push_count   = push_en ? push.count : 2'd0;
  assign count_popped = (pop && (count != '0)) ? count - 1'b1 : count;
  assign count_next   = count_popped + QCNT_W'(push_count);

  // Shift out the head on a pop, then append new results behind the rest.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && (i + 1 < QUEUE_DEPTH)) begin
        entries_next[i] = entries[i+1];
      end else begin
        entries_next[i] = entries[i];
      end
      if ((QCNT_W'(i) == count_popped) && (push_count != 2'd0)) begin
        entries_next[i] = push.first;
      end else if ((QCNT_W'(i) == count_popped + 1'b1) && (push_count == 2'd2)) begin
        entries_next[i] = push.second;
      end
    end
  end

  // Entry storage carries no reset; the count marks what is valid.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      entries[i] <= entries_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // A new row may bring two results, so keep two slots free.
  assign room       = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign head       = entries[0];
  assign head_valid = (count != '0);

endmodule

`default_nettype wire

### src/life_generation_row_stream.sv
// ---------------------------------------------------------------------------
// Life generation row stream
// One B3/S23 generation over a bounded grid, computed on a stream of rows.
// ---------------------------------------------------------------------------
// Rows enter top to bottom on the s_axis channel, one 64-bit row a request,
// bit j being cell j. Results leave on the m_axis channel: the next state of
// a row with its row number, and tlast on the final row of the frame.
// When row r is taken the block produces row r-1; the last row of a frame
// also produces itself, so a frame of H rows gives H results.
// The results of a row go into the result queue registers when the row is
// taken; a second one reaches the head once the first is taken. Throughput
// is one row per cycle while the receiver keeps up: 64 neighbor-count lanes
// work on a whole row combinationally. The last row of a frame brings two
// results and the three-entry result queue then holds off the input until
// one of them is taken. When the receiver stalls, the queue fills and
// s_axis_tready drops while fewer than two entries are free.
// Reset clears the stored rows and the row count and sets the grid to 64
// cells by 1024 rows. Configuration is written through cfg_we, cfg_index
// and cfg_data while the stream is idle, which the user must ensure as the
// block does not enforce it; width and height are clamped to legal ranges.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module life_generation_row_stream import lgr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration write port.
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // Input rows.
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [CELL_W-1:0]    s_axis_tdata,   // [63:0] row_cells
  // Result rows.
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OUT_W-1:0]          m_axis_tdata,   // [63:0] next_row_cells,
                                                    // [73:64] row_number, rest 0
  output logic                      m_axis_tlast    // frame_done
);

  logic [WIDTH_W-1:0]  grid_width;
  logic [HEIGHT_W-1:0] grid_height;
  logic [CELL_W-1:0]   upper_row;
  logic [CELL_W-1:0]   middle_row;
  logic [ROWNUM_W-1:0] rows_seen;
  logic [ROWNUM_W-1:0] rows_seen_next;

  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic [CELL_W-1:0]   mask;
  logic [CELL_W-1:0]   cur;
  logic [CELL_W-1:0]   up;
  logic [CELL_W-1:0]   mid;
  logic [CELL_W-1:0]   res_inner;
  logic [CELL_W-1:0]   res_last;
  logic                last_row;
  logic                accept;
  logic                room;
  lgr_push_t           push;
  lgr_result_t         head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= WIDTH_W'(64);
      grid_height <= HEIGHT_W'(1024);
    end else if (cfg_we) begin
      case (lgr_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_data[WIDTH_W-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp width and height into their legal ranges.
  always_comb begin
    width_eff = grid_width;
    if (grid_width == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (32'(grid_width) > ROW_BITS) begin
      width_eff = WIDTH_W'(ROW_BITS);
    end
    height_eff = grid_height;
    if (grid_height == '0) begin
      height_eff = HEIGHT_W'(1);
    end else if (32'(grid_height) > MAX_ROWS) begin
      height_eff = HEIGHT_W'(MAX_ROWS);
    end
  end

  // Cells at or beyond the width are ignored.
  always_comb begin
    for (int j = 0; j < CELL_W; j++) begin
      mask[j] = (WIDTH_W'(j) < width_eff);
    end
  end

  assign cur      = s_axis_tdata & mask;
  assign up       = upper_row & mask;
  assign mid      = middle_row & mask;
  assign last_row = (HEIGHT_W'(rows_seen) + 1'b1) >= height_eff;
  assign accept   = s_axis_tvalid && s_axis_tready;

  // Row r-1 from rows r-2, r-1 and r.
  lgr_row_unit u_inner (
    .above    (up),
    .mid      (mid),
    .below    (cur),
    .mask     (mask),
    .next_row (res_inner)
  );

  // Final row of the frame, with a dead row below it.
  lgr_row_unit u_last (
    .above    (mid),
    .mid      (cur),
    .below    ('0),
    .mask     (mask),
    .next_row (res_last)
  );

  // Results that the arriving row produces.
  always_comb begin
    push.second.cells = res_last;
    push.second.row   = rows_seen;
    push.second.done  = 1'b1;
    if (rows_seen == '0) begin
      push.count       = last_row ? 2'd1 : 2'd0;
      push.first.cells = res_last;
      push.first.row   = '0;
      push.first.done  = 1'b1;
    end else begin
      push.count       = last_row ? 2'd2 : 2'd1;
      push.first.cells = res_inner;
      push.first.row   = rows_seen - 1'b1;
      push.first.done  = 1'b0;
    end
  end

  assign rows_seen_next = last_row ? '0 : rows_seen + 1'b1;

  // Row history and row count.
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row  <= '0;
      middle_row <= '0;
      rows_seen  <= '0;
    end else if (accept) begin
      upper_row  <= last_row ? '0 : mid;
      middle_row <= last_row ? '0 : cur;
      rows_seen  <= rows_seen_next;
    end
  end

  lgr_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_en    (accept),
    .push       (push),
    .pop        (m_axis_tready),
    .head       (head),
    .head_valid (m_axis_tvalid),
    .room       (room)
  );

  assign s_axis_tready = room;
  assign m_axis_tdata  = {(OUT_W - OUT_BITS)'(0), head.row, head.cells};
  assign m_axis_tlast  = head.done;

  // A row past the first always leaves a result ready next cycle.
  `LGR_ASSERT(a_inner_result, clk, rst, (accept && (rows_seen != '0)) |=> m_axis_tvalid, "missing result after row")
  // The last row of a frame restarts the row count.
  `LGR_ASSERT(a_frame_restart, clk, rst, (accept && last_row) |=> (rows_seen == '0), "row count not cleared at frame end")
  // Any other row advances the count by one.
  `LGR_ASSERT(a_row_advance, clk, rst, (accept && !last_row) |=> (rows_seen == $past(rows_seen) + 1'b1), "row count did not advance")

endmodule

`default_nettype wire

### sim/life_generation_row_stream_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Life generation row stream testbench
// Streams grid rows into the block and checks every result row, its row
// number and its frame marker against a behavioral model of one B3/S23
// generation. A short table of directed rows and register writes comes
// first. Random frames follow under three handshake mixes, and the run ends
// with a long row run at a height past its limit under a long receiver stall.
// ---------------------------------------------------------------------------

module life_generation_row_stream_tb;
  import lgr_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_ROWS    = 60;
  localparam int CYCLE_LIMIT   = 400000;

  // Kinds of steps in the directed table.
  typedef enum logic [0:0] {
    STEP_CFG = 1'b0,
    STEP_ROW = 1'b1
  } step_kind_t;

  typedef struct packed {
    step_kind_t        kind;
    lgr_reg_t          regsel;
    logic [CFG_W-1:0]  value;
    logic [CELL_W-1:0] cells;
    logic              typed;
    logic [CELL_W-1:0] typed_cells;
  } directed_step_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [CELL_W-1:0]    s_axis_tdata;   // [63:0] row_cells
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;   // [63:0] next_row_cells, [73:64] row_number
  logic                 m_axis_tlast;   // frame_done

  // Model copy of the registers and the row window.
  logic [WIDTH_W-1:0]  grid_width_q  = WIDTH_W'(64);
  logic [HEIGHT_W-1:0] grid_height_q = HEIGHT_W'(1024);
  logic [CELL_W-1:0]   gen_upper     = '0;
  logic [CELL_W-1:0]   gen_middle    = '0;
  int                  gen_rows_seen = 0;

  lgr_result_t    expected_rows[$];
  directed_step_t directed_steps[$];

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  bit hold_results = 1'b0;
  int error_count  = 0;
  int cycle_count  = 0;

  life_generation_row_stream uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("life_generation_row_stream_tb failed");
      $finish;
    end
  end

  // Register values are clamped to their legal ranges before use.
  function automatic int active_width();
    int w;
    w = grid_width_q;
    if (w < 1) w = 1;
    if (w > ROW_BITS) w = ROW_BITS;
    return w;
  endfunction

  function automatic int active_height();
    int h;
    h = grid_height_q;
    if (h < 1) h = 1;
    if (h > MAX_ROWS) h = MAX_ROWS;
    return h;
  endfunction

  // Rows still missing from the current frame, at least one.
  function automatic int rows_left();
    int left;
    left = active_height() - gen_rows_seen;
    return (left < 1) ? 1 : left;
  endfunction

  // Next state of the middle row; cells beyond the row edges count as dead.
  function automatic logic [CELL_W-1:0] next_generation(input logic [CELL_W-1:0] above,
                                                        input logic [CELL_W-1:0] mid,
                                                        input logic [CELL_W-1:0] below,
                                                        input int w);
    logic [CELL_W-1:0] nxt;
    int j;
    int k;
    int n;
    nxt = '0;
    for (j = 0; j < w; j++) begin
      n = 0;
      for (k = j - 1; k <= j + 1; k++) begin
        if (k >= 0 && k < CELL_W) begin
          n = n + above[k] + below[k];
          if (k != j) n = n + mid[k];
        end
      end
      if (n == 3 || (mid[j] && n == 2)) nxt[j] = 1'b1;
    end
    return nxt;
  endfunction

  // Advance the row window by one accepted row and queue the rows it finishes.
  task automatic predict_generation_row(input logic [CELL_W-1:0] row_in);
    int                w;
    int                r;
    logic [CELL_W-1:0] mask;
    logic [CELL_W-1:0] cur;
    logic [CELL_W-1:0] up;
    logic [CELL_W-1:0] mid;
    bit                last_row;
    lgr_result_t       res;
    w = active_width();
    mask = (w >= CELL_W) ? '1 : ((CELL_W'(1) << w) - 1);
    cur = row_in & mask;
    up = gen_upper & mask;
    mid = gen_middle & mask;
    r = gen_rows_seen;
    last_row = (r + 1 >= active_height());
    if (r != 0) begin
      res.cells = next_generation(up, mid, cur, w);
      res.row = ROWNUM_W'(r - 1);
      res.done = 1'b0;
      expected_rows.push_back(res);
    end
    if (last_row) begin
      res.cells = next_generation((r == 0) ? '0 : mid, cur, '0, w);
      res.row = ROWNUM_W'(r);
      res.done = 1'b1;
      expected_rows.push_back(res);
      gen_upper = '0;
      gen_middle = '0;
      gen_rows_seen = 0;
    end else begin
      gen_upper = mid;
      gen_middle = cur;
      gen_rows_seen = r + 1;
    end
  endtask

  function automatic logic [CELL_W-1:0] random_row();
    logic [CELL_W-1:0] a;
    logic [CELL_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return a & b;
      3: return a | b;
      default: return a;
    endcase
  endfunction

  // Width values lean toward the clamp points; the bits above the register
  // are filled at random since the block drops them.
  function automatic logic [CFG_W-1:0] random_width_value();
    logic [CFG_W-1:0] value;
    value = CFG_W'($urandom);
    case ($urandom_range(7))
      0: value[WIDTH_W-1:0] = '0;
      1: value[WIDTH_W-1:0] = WIDTH_W'(1);
      2: value[WIDTH_W-1:0] = WIDTH_W'(64);
      3: value[WIDTH_W-1:0] = WIDTH_W'($urandom_range(65, 127));
      default: value[WIDTH_W-1:0] = WIDTH_W'($urandom_range(2, 63));
    endcase
    return value;
  endfunction

  // Heights stay small so that frames close often.
  function automatic logic [CFG_W-1:0] random_height_value();
    case ($urandom_range(7))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'($urandom_range(9, 40));
      default: return CFG_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic directed_step_t cfg_step(input lgr_reg_t regsel,
                                              input logic [CFG_W-1:0] value);
    directed_step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.regsel = regsel;
    s.value = value;
    return s;
  endfunction

  function automatic directed_step_t row_step(input logic [CELL_W-1:0] cells,
                                              input logic typed,
                                              input logic [CELL_W-1:0] typed_cells);
    directed_step_t s;
    s = '0;
    s.kind = STEP_ROW;
    s.cells = cells;
    s.typed = typed;
    s.typed_cells = typed_cells;
    return s;
  endfunction

  // Drop the row request and put junk on the data lines.
  task automatic stop_rows();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= {$urandom, $urandom};
  endtask

  // Offer one row, after random gaps, and hold it until the block takes it.
  // A typed expectation replaces the model's for single-row frames.
  task automatic send_row(input logic [CELL_W-1:0] cells, input logic typed,
                          input logic [CELL_W-1:0] typed_cells);
    lgr_result_t res;
    @(negedge clk);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= {$urandom, $urandom};
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= cells;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_generation_row(cells);
    if (typed) begin
      void'(expected_rows.pop_back());
      res.cells = typed_cells;
      res.row = '0;
      res.done = 1'b1;
      expected_rows.push_back(res);
    end
  endtask

  // Registers change only once the block has gone quiet.
  task automatic write_reg(input lgr_reg_t regsel, input logic [CFG_W-1:0] value);
    stop_rows();
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= regsel;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_data <= CFG_W'($urandom);
    if (regsel == REG_GRID_WIDTH) grid_width_q = value[WIDTH_W-1:0];
    else grid_height_q = value[HEIGHT_W-1:0];
  endtask

  // Random frames, mostly complete; now and then one is cut short and the
  // registers change in the middle of it.
  task automatic run_random_frames(input int rows_wanted);
    int sent;
    int frame_rows;
    sent = 0;
    while (sent < rows_wanted) begin
      if ($urandom_range(2) == 0) write_reg(REG_GRID_WIDTH, random_width_value());
      if ($urandom_range(2) == 0) write_reg(REG_GRID_HEIGHT, random_height_value());
      frame_rows = rows_left();
      if ($urandom_range(7) == 0) frame_rows = $urandom_range(1, frame_rows);
      repeat (frame_rows) send_row(random_row(), 1'b0, '0);
      sent += frame_rows;
    end
  endtask

  task automatic report_mismatch(input string field, input logic [CELL_W-1:0] want,
                                 input logic [CELL_W-1:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  // Result sink: random stalls, or one long hold when asked for.
  initial begin : result_sink
    int held;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        m_axis_tready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_results = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // Every result request is matched against the oldest expected row.
  always @(posedge clk) begin : result_check
    lgr_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_rows.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual cells %h row %0d last %b",
                 $time, m_axis_tdata[CELL_W-1:0], m_axis_tdata[CELL_W +: ROWNUM_W],
                 m_axis_tlast);
      end else begin
        want = expected_rows.pop_front();
        if (m_axis_tdata[CELL_W-1:0] !== want.cells)
          report_mismatch("next_row_cells", want.cells, m_axis_tdata[CELL_W-1:0]);
        if (m_axis_tdata[CELL_W +: ROWNUM_W] !== want.row)
          report_mismatch("row_number", CELL_W'(want.row),
                          CELL_W'(m_axis_tdata[CELL_W +: ROWNUM_W]));
        if (m_axis_tlast !== want.done)
          report_mismatch("frame_done", CELL_W'(want.done), CELL_W'(m_axis_tlast));
      end
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_GRID_WIDTH;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;

    // Directed rows. Single-row frames carry their expected cells; the
    // rest go through the model.
    // Reset geometry, then the height drops to one in the middle of a frame
    // so the next row closes it.
    directed_steps.push_back(row_step('1, 1'b0, '0));
    directed_steps.push_back(row_step(64'hA5A5_A5A5_A5A5_A5A5, 1'b0, '0));
    directed_steps.push_back(row_step('0, 1'b0, '0));
    directed_steps.push_back(cfg_step(REG_GRID_HEIGHT, CFG_W'(1)));
    directed_steps.push_back(row_step('1, 1'b0, '0));
    // One-row frames: no neighbors above or below, no wrap at the edges.
    directed_steps.push_back(row_step('0, 1'b1, '0));
    directed_steps.push_back(row_step('1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE));
    directed_steps.push_back(row_step(64'h7, 1'b1, 64'h2));
    // Width zero acts as one.
    directed_steps.push_back(cfg_step(REG_GRID_WIDTH, CFG_W'(11'h780)));
    directed_steps.push_back(row_step('1, 1'b1, '0));
    // Width above the row size acts as the full row.
    directed_steps.push_back(cfg_step(REG_GRID_WIDTH, CFG_W'(127)));
    directed_steps.push_back(row_step('1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE));
    // Height zero acts as one.
    directed_steps.push_back(cfg_step(REG_GRID_HEIGHT, '0));
    directed_steps.push_back(row_step(64'hE000_0000_0000_0007, 1'b1,
                                      64'h4000_0000_0000_0002));
    // Narrow grid, a vertical blinker, junk above the width.
    directed_steps.push_back(cfg_step(REG_GRID_WIDTH, CFG_W'(5)));
    directed_steps.push_back(cfg_step(REG_GRID_HEIGHT, CFG_W'(3)));
    directed_steps.push_back(row_step(64'hFFFF_FFFF_FFFF_FFE4, 1'b0, '0));
    directed_steps.push_back(row_step(64'h0000_0000_0000_0004, 1'b0, '0));
    directed_steps.push_back(row_step(64'h8000_0000_0000_0024, 1'b0, '0));
    // One cell wide, two rows high.
    directed_steps.push_back(cfg_step(REG_GRID_WIDTH, CFG_W'(1)));
    directed_steps.push_back(cfg_step(REG_GRID_HEIGHT, CFG_W'(2)));
    directed_steps.push_back(row_step('1, 1'b0, '0));
    directed_steps.push_back(row_step('0, 1'b0, '0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sender idles lightly, receiver heavily.
    send_gap_pct = 25;
    recv_gap_pct = 82;
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_CFG)
        write_reg(directed_steps[i].regsel, directed_steps[i].value);
      else
        send_row(directed_steps[i].cells, directed_steps[i].typed,
                 directed_steps[i].typed_cells);
    end
    run_random_frames(150);

    // Sender idles heavily, receiver lightly.
    send_gap_pct = 82;
    recv_gap_pct = 25;
    run_random_frames(150);

    // Full rate both ways.
    send_gap_pct = 0;
    recv_gap_pct = 0;
    run_random_frames(120);

    // A long run of rows with the height past its limit, the receiver
    // stalled at its start so the result queue fills and holds off the input.
    write_reg(REG_GRID_WIDTH, CFG_W'(64));
    write_reg(REG_GRID_HEIGHT, CFG_W'(11'h7FF));
    hold_results = 1'b1;
    repeat (STALL_ROWS) send_row(random_row(), 1'b0, '0);

    stop_rows();
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (error_count == 0) begin
      $display("life_generation_row_stream_tb passed");
    end else begin
      $display("life_generation_row_stream_tb failed");
    end
    $finish;
  end

endmodule
